/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is applied.
`define SBD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define SBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/sbd_pkg.sv */
// ----------------------------------------------------------------------------
// sbd_pkg
// Types, constants and codes shared by the bulk-dump receiver modules.
// ----------------------------------------------------------------------------
package sbd_pkg;

  // Largest number of data bytes in one dump block (1 to 64).
  localparam int MAX_DATA  = 64;
  localparam int IDX_W     = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int CNT_W     = $clog2(MAX_DATA + 1);
  localparam int MEM_AW    = IDX_W + 1;
  localparam int MEM_DEPTH = 2 ** MEM_AW;

  // MIDI byte codes.
  localparam logic [7:0] SYX_START  = 8'hF0;
  localparam logic [7:0] SYX_END    = 8'hF7;
  localparam logic [7:0] RT_FIRST   = 8'hF8;
  localparam logic [7:0] MFR_ID     = 8'h43;
  localparam logic [7:0] DEV_MASK   = 8'h70;
  localparam logic [7:0] GROUP_ID   = 8'h7F;
  localparam logic [7:0] FORMAT_ID  = 8'h1C;

  // Byte positions within a frame, counted from the opening F0.
  localparam logic [7:0] POS_MFR     = 8'd1;
  localparam logic [7:0] POS_DEV     = 8'd2;
  localparam logic [7:0] POS_GROUP   = 8'd3;
  localparam logic [7:0] POS_FORMAT  = 8'd4;
  localparam logic [7:0] POS_CNT_HI  = 8'd5;
  localparam logic [7:0] POS_CNT_LO  = 8'd6;
  localparam logic [7:0] POS_MODEL   = 8'd7;
  localparam logic [7:0] POS_ADDR_H  = 8'd8;
  localparam logic [7:0] POS_ADDR_M  = 8'd9;
  localparam logic [7:0] POS_ADDR_L  = 8'd10;
  localparam logic [7:0] POS_DATA    = 8'd11;
  localparam logic [7:0] POS_SAT     = 8'd255;
  localparam logic [7:0] POS_LIMIT   = 8'(MAX_DATA + 12);
  localparam logic [7:0] POS_DATA_END = 8'(MAX_DATA + 11);

  // Header bytes counted in the declared length besides the data.
  localparam logic [13:0] CNT_HDR   = 14'd4;
  localparam logic [14:0] LEN_EXTRA = 15'd9;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_RECOG = 3'd1,
    ST_LEN_ERR   = 3'd2,
    ST_BAD_MODEL = 3'd3,
    ST_BAD_SUM   = 3'd4,
    ST_TOO_LONG  = 3'd5
  } sbd_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_BURST
  } sbd_back_state_t;

  // One judged frame, passed from the parser to the emitter.
  typedef struct packed {
    sbd_status_t      status;
    logic [6:0]       addr_high;
    logic [6:0]       addr_mid;
    logic [6:0]       addr_low;
    logic [CNT_W-1:0] count;
    logic             bank;
  } sbd_cmd_t;

  // Write port of the data buffer.
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [6:0]        data;
  } sbd_wr_t;

  // Buffer bank handed back by the emitter after its last read.
  typedef struct packed {
    logic valid;
    logic bank;
  } sbd_rel_t;

endpackage

/* rtl/core/sbd_ifs.sv */
// ----------------------------------------------------------------------------
// sbd_byte_if / sbd_item_if
// Valid/ready channels for incoming MIDI bytes and outgoing result items.
// ----------------------------------------------------------------------------
interface sbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface

interface sbd_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] addr_high;
  logic [6:0] addr_mid;
  logic [6:0] addr_low;
  logic [5:0] data_index;
  logic [6:0] data_byte;
  logic       data_valid;
  logic       last;

  modport source (output valid, output status, output addr_high, output addr_mid,
                  output addr_low, output data_index, output data_byte,
                  output data_valid, output last, input ready);
  modport sink   (input valid, input status, input addr_high, input addr_mid,
                  input addr_low, input data_index, input data_byte,
                  input data_valid, input last, output ready);
endinterface

/* rtl/core/sbd_ram.sv */
// ----------------------------------------------------------------------------
// sbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sbd_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/sbd_front.sv */
// ----------------------------------------------------------------------------
// sbd_front
// Byte parser: tracks the frame, writes data bytes to the buffer and judges
// the frame at its closing byte.
// ----------------------------------------------------------------------------
module sbd_front import sbd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  sbd_byte_if.sink       in_ch,
  input  logic [6:0]     model_id,
  input  logic           cmd_full,
  output logic           cmd_push,
  output sbd_cmd_t       cmd,
  output sbd_wr_t        wr,
  input  sbd_rel_t       rel
);

  logic        in_frame;
  logic [7:0]  bpos;
  logic        hdr_ok;
  logic [13:0] dcount;
  logic [6:0]  rsum;
  logic [6:0]  model;
  logic [6:0]  addr_h, addr_m, addr_l;
  logic        wr_bank;
  logic [1:0]  bank_busy;

  logic        accept;
  logic [7:0]  b;
  logic [6:0]  b7;
  logic        is_rt, is_start, is_data, is_end;
  logic        take;
  sbd_status_t verdict;
  logic [CNT_W-1:0] n_data;
  logic        uses_bank;

  // A bank is written only after the emitter is done with it.
  assign in_ch.ready = !cmd_full && !bank_busy[wr_bank];
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.midi_byte;
  assign b7          = b[6:0];
  assign is_rt       = (b >= RT_FIRST);
  assign is_start    = (b == SYX_START);
  assign is_data     = !b[7];
  assign is_end      = (b == SYX_END);
  assign take        = accept && in_frame && is_data;

  always_comb begin
    if (!hdr_ok || bpos < POS_CNT_HI) begin
      verdict = ST_NOT_RECOG;
    end else if (bpos > POS_LIMIT) begin
      verdict = ST_TOO_LONG;
    end else if (dcount < CNT_HDR ||
                 ({7'd0, bpos} + 15'd1) != ({1'b0, dcount} + LEN_EXTRA)) begin
      verdict = ST_LEN_ERR;
    end else if (model != model_id) begin
      verdict = ST_BAD_MODEL;
    end else if (rsum != 7'd0) begin
      verdict = ST_BAD_SUM;
    end else begin
      verdict = ST_OK;
    end
  end

  assign n_data    = CNT_W'(dcount - CNT_HDR);
  assign cmd_push  = accept && in_frame && is_end;
  assign uses_bank = (verdict == ST_OK) && (n_data != '0);

  always_comb begin
    cmd.status    = verdict;
    cmd.bank      = wr_bank;
    if (verdict == ST_OK) begin
      cmd.addr_high = addr_h;
      cmd.addr_mid  = addr_m;
      cmd.addr_low  = addr_l;
      cmd.count     = n_data;
    end else begin
      cmd.addr_high = '0;
      cmd.addr_mid  = '0;
      cmd.addr_low  = '0;
      cmd.count     = '0;
    end
  end

  assign wr.en   = take && bpos >= POS_DATA && bpos < POS_DATA_END;
  assign wr.addr = {wr_bank, IDX_W'(bpos - POS_DATA)};
  assign wr.data = b7;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      bpos     <= '0;
      hdr_ok   <= 1'b0;
      dcount   <= '0;
      rsum     <= '0;
      model    <= '0;
      addr_h   <= '0;
      addr_m   <= '0;
      addr_l   <= '0;
    end else if (accept && !is_rt) begin
      if (is_start) begin
        in_frame <= 1'b1;
        bpos     <= POS_MFR;
        hdr_ok   <= 1'b1;
        dcount   <= '0;
        rsum     <= '0;
        model    <= '0;
        addr_h   <= '0;
        addr_m   <= '0;
        addr_l   <= '0;
      end else if (in_frame && is_data) begin
        case (bpos)
          POS_MFR:    if (b != MFR_ID) hdr_ok <= 1'b0;
          POS_DEV:    if ((b & DEV_MASK) != 8'd0) hdr_ok <= 1'b0;
          POS_GROUP:  if (b != GROUP_ID) hdr_ok <= 1'b0;
          POS_FORMAT: if (b != FORMAT_ID) hdr_ok <= 1'b0;
          POS_CNT_HI: dcount[13:7] <= b7;
          POS_CNT_LO: dcount[6:0]  <= b7;
          POS_MODEL:  model  <= b7;
          POS_ADDR_H: addr_h <= b7;
          POS_ADDR_M: addr_m <= b7;
          POS_ADDR_L: addr_l <= b7;
          default: ;
        endcase
        if (bpos >= POS_MODEL) begin
          rsum <= rsum + b7;
        end
        if (bpos != POS_SAT) begin
          bpos <= bpos + 8'd1;
        end
      end else if (in_frame) begin
        in_frame <= 1'b0;
      end
    end
  end

  // Bank ownership: a frame that leaves data for the emitter takes its bank
  // along, and the parser moves on to the other one.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_bank   <= 1'b0;
      bank_busy <= '0;
    end else begin
      if (rel.valid) begin
        bank_busy[rel.bank] <= 1'b0;
      end
      if (cmd_push && uses_bank) begin
        bank_busy[wr_bank] <= 1'b1;
        wr_bank            <= !wr_bank;
      end
    end
  end

endmodule

/* rtl/core/sbd_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// sbd_cmd_fifo
// Two-entry queue of judged frames between parser and emitter.
// ----------------------------------------------------------------------------
module sbd_cmd_fifo import sbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  sbd_cmd_t push_cmd,
  input  logic     pop,
  output sbd_cmd_t head,
  output logic     empty,
  output logic     full
);

  sbd_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign head  = slots[rd_ptr];
  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

/* rtl/core/sbd_back.sv */
// ----------------------------------------------------------------------------
// sbd_back
// Emitter: turns each judged frame into result items, reading data bytes
// from the buffer one per item into the buffer's read register.
// ----------------------------------------------------------------------------
module sbd_back import sbd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  sbd_cmd_t          cmd,
  output logic              cmd_pop,
  output logic              rd_en,
  output logic [MEM_AW-1:0] rd_addr,
  input  logic [6:0]        rd_data,
  output sbd_rel_t          rel,
  sbd_item_if.source        out_ch
);

  sbd_back_state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  sbd_cmd_t         cur, cur_next;

  logic       out_valid;
  logic [2:0] out_status;
  logic [6:0] out_ah, out_am, out_al;
  logic [5:0] out_idx;
  logic       out_dv;
  logic       out_last;

  logic       load;
  logic [2:0] ld_status;
  logic [6:0] ld_ah, ld_am, ld_al;
  logic [5:0] ld_idx;
  logic       ld_dv;
  logic       ld_last;
  logic       room;

  assign room = !out_valid || out_ch.ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cur_next   = cur;
    cmd_pop    = 1'b0;
    load       = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = {cur.bank, IDX_W'(cnt)};
    rel.valid  = 1'b0;
    rel.bank   = cur.bank;
    ld_status  = ST_OK;
    ld_ah      = cur.addr_high;
    ld_am      = cur.addr_mid;
    ld_al      = cur.addr_low;
    ld_idx     = 6'(cnt);
    ld_dv      = 1'b1;
    ld_last    = (cnt == cur.count - CNT_W'(1));
    case (state)
      BK_IDLE: begin
        ld_ah = cmd.addr_high;
        ld_am = cmd.addr_mid;
        ld_al = cmd.addr_low;
        ld_idx = '0;
        if (!cmd_empty && room) begin
          cmd_pop   = 1'b1;
          load      = 1'b1;
          ld_status = cmd.status;
          if (cmd.status != ST_OK || cmd.count == '0) begin
            ld_dv   = 1'b0;
            ld_last = 1'b1;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = {cmd.bank, IDX_W'(0)};
            ld_last   = (cmd.count == CNT_W'(1));
            rel.bank  = cmd.bank;
            rel.valid = ld_last;
            if (!ld_last) begin
              cur_next   = cmd;
              cnt_next   = CNT_W'(1);
              state_next = BK_BURST;
            end
          end
        end
      end
      BK_BURST: begin
        if (room) begin
          load      = 1'b1;
          rd_en     = 1'b1;
          rel.valid = ld_last;
          if (ld_last) begin
            state_next = BK_IDLE;
          end else begin
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (load) begin
      out_status <= ld_status;
      out_ah     <= ld_ah;
      out_am     <= ld_am;
      out_al     <= ld_al;
      out_idx    <= ld_idx;
      out_dv     <= ld_dv;
      out_last   <= ld_last;
    end
  end

  // The buffer's read register is loaded together with the output register.
  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_status;
  assign out_ch.addr_high  = out_ah;
  assign out_ch.addr_mid   = out_am;
  assign out_ch.addr_low   = out_al;
  assign out_ch.data_index = out_idx;
  assign out_ch.data_byte  = out_dv ? rd_data : 7'd0;
  assign out_ch.data_valid = out_dv;
  assign out_ch.last       = out_last;

endmodule

/* rtl/core/sysex_bulk_dump_receiver.sv */
// ----------------------------------------------------------------------------
// sysex_bulk_dump_receiver
// Receives MIDI bytes, recognizes bulk-dump SysEx frames and emits their data.
// ----------------------------------------------------------------------------
// Usage:
// MIDI bytes arrive on in_ch, one per beat. Every byte is taken while ready is
// high, including real-time and stray bytes, which are simply dropped. Results
// leave on out_ch: a valid frame gives one beat per data byte with its address
// and index, an empty block or a rejected frame gives a single status beat. The
// final beat of a frame has last set.
// Timing: the parser takes one byte per cycle while ready is high. The closing
// F7 puts the judged frame into the frame queue; the emitter loads its first
// beat from there into the output register and sends one beat per cycle while
// out_ch is ready. The data buffer has two banks; the parser stalls only when
// both banks still hold undelivered data or two judged frames are queued, so a
// burst of up to 64 beats overlaps with reception of the next frame. A stall on
// out_ch holds the output register; the parser keeps running until the buffer
// banks or the two-entry frame queue fill, and then drops ready. Reset (rst,
// synchronous) clears the frame tracking, the queue and the output register,
// and sets model_id to zero; the buffer itself is not cleared. The user writes
// model_id through cfg_we/cfg_data while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sysex_bulk_dump_receiver import sbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  sbd_byte_if.sink    in_ch,
  sbd_item_if.source  out_ch
);

  logic [6:0]        model_id;
  logic              cmd_push;
  logic              cmd_pop;
  logic              cmd_empty;
  logic              cmd_full;
  sbd_cmd_t          push_cmd;
  sbd_cmd_t          head_cmd;
  sbd_wr_t           wr;
  sbd_rel_t          rel;
  logic              rd_en;
  logic [MEM_AW-1:0] rd_addr;
  logic [6:0]        rd_data;

  // Model identifier register; a frame must carry this byte to be accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      model_id <= '0;
    end else if (cfg_we) begin
      model_id <= cfg_data;
    end
  end

  // Parser: frame tracking, header and checksum checks, buffer writes.
  sbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .model_id (model_id),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (push_cmd),
    .wr       (wr),
    .rel      (rel)
  );

  // Judged frames wait here so that parser and emitter stall independently.
  sbd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head     (head_cmd),
    .empty    (cmd_empty),
    .full     (cmd_full)
  );

  // Two banks of data bytes; the bank bit is the top address bit.
  sbd_ram #(
    .WIDTH (7),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Emitter: one result beat per cycle from the queued frame while out_ch is ready.
  sbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rel       (rel),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/core/sbd_checker.sv */
// ----------------------------------------------------------------------------
// sbd_checker
// Port-level checks on the result channel of the bulk-dump receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbd_checker import sbd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       data_valid,
  input logic       last
);

  // A beat offered but not taken is still offered in the next cycle.
  `SBD_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "out beat dropped")

  // A rejected frame is reported by one beat that closes the frame.
  `SBD_ASSERT(a_err_single, clk, rst, out_valid && status != ST_OK |-> last && !data_valid, "error beat malformed")

  // Data bytes are only ever delivered for a frame that passed every check.
  `SBD_ASSERT(a_data_ok, clk, rst, out_valid && data_valid |-> status == ST_OK, "data beat with error status")

  // Reset leaves the result channel empty.
  `SBD_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !out_valid, "out valid after reset")

endmodule

bind sysex_bulk_dump_receiver sbd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .data_valid (out_ch.data_valid),
  .last       (out_ch.last)
);
